@@ hw/rtl/cntc_pkg.sv @@
// Shared types, codes and defaults of the channel noise trigger counter.
`default_nettype none

package cntc_pkg;

  // Default geometry and counter width.
  localparam int DefLayers    = 15;
  localparam int DefChips     = 16;
  localparam int DefChannels  = 64;
  localparam int DefCells     = 15;
  localparam int DefCountBits = 24;

  // Command codes.
  localparam logic [1:0] OP_EVENT  = 2'd0;
  localparam logic [1:0] OP_SAMPLE = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_LAYERS_IN_USE  = 2'd0;
  localparam logic [1:0] REG_EXPECTED_NOISE = 2'd1;
  localparam logic [1:0] REG_CHARGE_LOW     = 2'd2;
  localparam logic [1:0] REG_CHARGE_HIGH    = 2'd3;

  // Register reset values.
  localparam logic [3:0]  LAYERS_IN_USE_RST  = 4'd15;
  localparam logic [23:0] EXPECTED_NOISE_RST = 24'd0;
  localparam logic [11:0] CHARGE_LOW_RST     = 12'd100;
  localparam logic [11:0] CHARGE_HIGH_RST    = 12'd1000;

  // Quality code above which a cell is a retrigger.
  localparam logic signed [7:0] RETRIG_CODE_MIN = 8'sd2;

  // Width of a cell index.
  localparam int CellW = 4;

  // One command transaction.
  typedef struct packed {
    logic [1:0]        op;
    logic [3:0]        layer;
    logic [3:0]        chip;
    logic [3:0]        cell_req;
    logic [5:0]        channel;
    logic              cell_valid;
    logic signed [7:0] bad_bcid;
    logic              hit_high;
    logic [11:0]       charge;
  } in_item_t;

  // One readout result transaction.
  typedef struct packed {
    logic [3:0]  out_layer;
    logic [3:0]  out_chip;
    logic [5:0]  out_channel;
    logic [23:0] expected;
    logic [23:0] triggers;
    logic [23:0] retrigger_starts;
    logic [23:0] retrigger_trains;
    logic [23:0] out_of_range_charges;
  } out_item_t;

endpackage

`default_nettype wire

@@ hw/rtl/cntc_count_ram.sv @@
// Counter memory: one word holds all four counters of a channel entry.
`default_nettype none

module cntc_count_ram #(
  parameter int DEPTH = 15360,
  parameter int WIDTH = 96,
  parameter int ADDR_W = 14
) (
  input  wire logic              clk,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/cntc_mark_store.sv @@
// First-retrigger marks per chip: seen flags in flops, cell index in memory.
`default_nettype none

module cntc_mark_store
  import cntc_pkg::*;
#(
  parameter int DEPTH = 240,
  parameter int IDX_W = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             clear_all,
  input  wire logic             rd_en,
  input  wire logic [IDX_W-1:0] rd_idx,
  output logic                  seen_q,
  output logic      [CellW-1:0] cell_q,
  input  wire logic             set_en,
  input  wire logic [IDX_W-1:0] set_idx,
  input  wire logic [CellW-1:0] set_cell
);

  logic [DEPTH-1:0] seen;
  logic [CellW-1:0] cell_mem [DEPTH];

  // Seen flags: cleared together at reset and at every event start.
  always_ff @(posedge clk) begin
    if (rst || clear_all) begin
      seen <= '0;
    end else if (set_en) begin
      seen[set_idx] <= 1'b1;
    end
  end

  // Cell index memory, written when a chip gets its first retrigger mark.
  always_ff @(posedge clk) begin
    if (set_en) begin
      cell_mem[set_idx] <= set_cell;
    end
  end

  // Registered read of flag and cell index.
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_q <= 1'b0;
    end else if (rd_en) begin
      seen_q <= seen[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      cell_q <= cell_mem[rd_idx];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/channel_noise_trigger_counter_core.sv @@
// Top level of the channel noise trigger counter.
//
// Commands enter on item with start; a command transaction is accepted at a
// clock edge where start is high and busy is low. Op event start clears the
// per-chip first-retrigger marks, op sample updates the four saturating
// counters of one (layer, chip, channel) entry, op read returns them.
// The edge of acceptance issues a read of the counter memory and the mark
// store, and the following cycle modifies and writes back. busy is high for
// that cycle, so a new command is not taken before the last is written back;
// this is set by the registered read of the counter memory ahead of its
// write-back.
// A read result is registered at the end of the modify cycle and shows on
// result with result_valid high for exactly one cycle. The receiver cannot
// stall; a result is never held.
// Configuration is written through cfg_we, cfg_index and cfg_data at any edge.
// After reset the block sweeps the counter memory to zero, one entry a cycle,
// covering LAYERS*CHIPS*CHANNELS entries (15360 by default), busy high throughout.
`default_nettype none

module channel_noise_trigger_counter_core
  import cntc_pkg::*;
#(
  parameter int LAYERS     = DefLayers,
  parameter int CHIPS      = DefChips,
  parameter int CHANNELS   = DefChannels,
  parameter int CELLS      = DefCells,
  parameter int COUNT_BITS = DefCountBits
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire in_item_t    item,
  output logic             result_valid,
  output out_item_t        result,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [23:0] cfg_data
);

  localparam int NumChips   = LAYERS * CHIPS;
  localparam int NumEntries = NumChips * CHANNELS;
  localparam int ChipIdxW   = (NumChips > 1) ? $clog2(NumChips) : 1;
  localparam int EntryW     = (NumEntries > 1) ? $clog2(NumEntries) : 1;
  localparam int WordW      = 4 * COUNT_BITS;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  typedef logic [COUNT_BITS-1:0] count_t;

  // Saturating increment.
  function automatic count_t bump(input count_t val);
    bump = (val == '1) ? val : val + count_t'(1);
  endfunction

  // Configuration registers.
  logic [3:0]  layers_in_use;
  logic [23:0] expected_noise;
  logic [11:0] charge_low;
  logic [11:0] charge_high;

  always_ff @(posedge clk) begin
    if (rst) begin
      layers_in_use  <= LAYERS_IN_USE_RST;
      expected_noise <= EXPECTED_NOISE_RST;
      charge_low     <= CHARGE_LOW_RST;
      charge_high    <= CHARGE_HIGH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LAYERS_IN_USE:  layers_in_use  <= cfg_data[3:0];
        REG_EXPECTED_NOISE: expected_noise <= cfg_data;
        REG_CHARGE_LOW:     charge_low     <= cfg_data[11:0];
        REG_CHARGE_HIGH:    charge_high    <= cfg_data[11:0];
        default:            ;
      endcase
    end
  end

  // Control state.
  logic              state;
  logic              state_next;
  logic              clearing;
  logic [EntryW-1:0] clr_addr;
  logic              accept;

  assign busy   = clearing || (state != ST_IDLE);
  assign accept = start && !busy;

  // Address decode of the incoming command.
  logic                in_range;
  logic                sample_ok;
  logic [ChipIdxW-1:0] chip_idx;
  logic [EntryW-1:0]   entry_idx;
  logic [31:0]         chip_lin;

  always_comb begin
    in_range  = (32'(item.layer) < LAYERS) && (32'(item.chip) < CHIPS) &&
                (32'(item.channel) < CHANNELS);
    sample_ok = item.cell_valid && in_range && (item.layer < layers_in_use) &&
                (32'(item.cell_req) < CELLS);
    chip_lin  = in_range ? (32'(item.layer) * CHIPS + 32'(item.chip)) : 32'd0;
    chip_idx  = ChipIdxW'(chip_lin);
    entry_idx = in_range ? EntryW'(chip_lin * CHANNELS + 32'(item.channel)) : '0;
  end

  // Command held for the modify cycle.
  in_item_t            item_q;
  logic                in_range_q;
  logic                sample_ok_q;
  logic [ChipIdxW-1:0] chip_idx_q;
  logic [EntryW-1:0]   entry_idx_q;

  always_ff @(posedge clk) begin
    if (accept) begin
      item_q      <= item;
      in_range_q  <= in_range;
      sample_ok_q <= sample_ok;
      chip_idx_q  <= chip_idx;
      entry_idx_q <= entry_idx;
    end
  end

  // Sequencer: idle, then a modify and write-back state.
  always_comb begin
    case (state)
      ST_IDLE: state_next = accept ? ST_EXEC : ST_IDLE;
      ST_EXEC: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Clearing sweep of the counter memory after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == EntryW'(NumEntries - 1)) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + EntryW'(1);
    end
  end

  // Storage.
  logic [WordW-1:0]    rd_word;
  logic [WordW-1:0]    wr_word;
  logic                ram_we;
  logic [EntryW-1:0]   ram_waddr;
  logic [WordW-1:0]    ram_wdata;
  logic                seen_q;
  logic [CellW-1:0]    mark_cell_q;
  logic                mark_set;
  logic                mark_clear;
  logic                cnt_we;

  cntc_count_ram #(
    .DEPTH  (NumEntries),
    .WIDTH  (WordW),
    .ADDR_W (EntryW)
  ) u_count_ram (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (entry_idx),
    .rd_data (rd_word),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata)
  );

  cntc_mark_store #(
    .DEPTH (NumChips),
    .IDX_W (ChipIdxW)
  ) u_mark_store (
    .clk       (clk),
    .rst       (rst),
    .clear_all (mark_clear),
    .rd_en     (accept),
    .rd_idx    (chip_idx),
    .seen_q    (seen_q),
    .cell_q    (mark_cell_q),
    .set_en    (mark_set),
    .set_idx   (chip_idx_q),
    .set_cell  (item_q.cell_req)
  );

  // Counter update for a sample.
  count_t trig_c, start_c, train_c, oor_c;
  logic   exec;
  logic   retrig;
  logic   clean;
  logic   first_cell;
  logic   charge_out;

  always_comb begin
    exec       = (state == ST_EXEC);
    trig_c     = rd_word[COUNT_BITS-1:0];
    start_c    = rd_word[2*COUNT_BITS-1:COUNT_BITS];
    train_c    = rd_word[3*COUNT_BITS-1:2*COUNT_BITS];
    oor_c      = rd_word[4*COUNT_BITS-1:3*COUNT_BITS];
    retrig     = item_q.bad_bcid > RETRIG_CODE_MIN;
    clean      = (item_q.bad_bcid == 8'sd0);
    first_cell = !seen_q || (mark_cell_q == item_q.cell_req);
    charge_out = (item_q.charge < charge_low) || (item_q.charge > charge_high);
    cnt_we     = exec && (item_q.op == OP_SAMPLE) && sample_ok_q;
    mark_set   = cnt_we && retrig && !seen_q;
    mark_clear = exec && (item_q.op == OP_EVENT);

    wr_word = rd_word;
    if (item_q.hit_high) begin
      if (retrig) begin
        wr_word[3*COUNT_BITS-1:2*COUNT_BITS] = bump(train_c);
        if (first_cell) begin
          wr_word[2*COUNT_BITS-1:COUNT_BITS] = bump(start_c);
          if (charge_out) begin
            wr_word[4*COUNT_BITS-1:3*COUNT_BITS] = bump(oor_c);
          end
        end
      end else if (clean) begin
        wr_word[COUNT_BITS-1:0] = bump(trig_c);
      end
    end

    // The clearing sweep owns the write port until it ends.
    ram_we    = clearing || cnt_we;
    ram_waddr = clearing ? clr_addr : entry_idx_q;
    ram_wdata = clearing ? '0 : wr_word;
  end

  // Readout result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= exec && (item_q.op == OP_READ);
    end
  end

  always_ff @(posedge clk) begin
    if (exec && (item_q.op == OP_READ)) begin
      result.out_layer            <= item_q.layer;
      result.out_chip             <= item_q.chip;
      result.out_channel          <= item_q.channel;
      result.expected             <= expected_noise;
      result.triggers             <= in_range_q ? 24'(trig_c) : 24'd0;
      result.retrigger_starts     <= in_range_q ? 24'(start_c) : 24'd0;
      result.retrigger_trains     <= in_range_q ? 24'(train_c) : 24'd0;
      result.out_of_range_charges <= in_range_q ? 24'(oor_c) : 24'd0;
    end
  end

endmodule

`default_nettype wire

@@ test/tb.sv @@
// Self-checking testbench for the channel noise trigger counter core.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cntc_pkg::*;

  localparam int NumEntries = DefLayers * DefChips * DefChannels;
  localparam int NumChips   = DefLayers * DefChips;

  // Op code that the block does not use.
  localparam logic [1:0] OP_SPARE = 2'd3;

  typedef struct packed {
    logic [3:0] layer;
    logic [3:0] chip;
    logic [5:0] channel;
  } entry_addr_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  in_item_t    item = '0;
  logic        result_valid;
  out_item_t   result;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;

  channel_noise_trigger_counter_core dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .result_valid (result_valid),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Predicted counter state and register copies.
  logic [23:0] trig_cnt  [NumEntries];
  logic [23:0] start_cnt [NumEntries];
  logic [23:0] train_cnt [NumEntries];
  logic [23:0] range_cnt [NumEntries];
  bit          retrig_seen [NumChips];
  logic [3:0]  retrig_cell [NumChips];
  logic [3:0]  lim_layers;
  logic [23:0] noise_level;
  logic [11:0] win_lo;
  logic [11:0] win_hi;

  in_item_t    pending_cmds[$];
  out_item_t   expected_readouts[$];
  entry_addr_t hit_addrs[$];
  logic [3:0]  hot_chips[3];
  logic [5:0]  hot_chans[4];
  bit          idle_on = 1'b0;
  int unsigned gap_left = 0;
  int          mismatches = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb: FAIL");
    $finish;
  end

  function automatic logic [23:0] sat_inc(logic [23:0] v);
    return (v == '1) ? v : v + 24'd1;
  endfunction

  // Apply one accepted command to the predicted state; queue the readout if any.
  function automatic void apply_command(in_item_t c);
    int unsigned chip_ix;
    int unsigned ent;
    bit          addr_ok;
    out_item_t   r;
    addr_ok = c.layer < DefLayers && c.chip < DefChips && c.channel < DefChannels;
    chip_ix = addr_ok ? c.layer * DefChips + c.chip : 0;
    ent = chip_ix * DefChannels + c.channel;
    case (c.op)
      OP_EVENT: begin
        foreach (retrig_seen[i]) retrig_seen[i] = 1'b0;
      end
      OP_SAMPLE: begin
        if (c.cell_valid && addr_ok && c.layer < lim_layers && c.cell_req < DefCells) begin
          if ($signed(c.bad_bcid) > RETRIG_CODE_MIN) begin
            if (!retrig_seen[chip_ix]) begin
              retrig_seen[chip_ix] = 1'b1;
              retrig_cell[chip_ix] = c.cell_req;
            end
            if (c.hit_high) begin
              train_cnt[ent] = sat_inc(train_cnt[ent]);
              if (retrig_cell[chip_ix] == c.cell_req) begin
                start_cnt[ent] = sat_inc(start_cnt[ent]);
                if (c.charge < win_lo || c.charge > win_hi)
                  range_cnt[ent] = sat_inc(range_cnt[ent]);
              end
            end
          end else if (c.bad_bcid == 8'd0 && c.hit_high) begin
            trig_cnt[ent] = sat_inc(trig_cnt[ent]);
          end
        end
      end
      OP_READ: begin
        r.out_layer            = c.layer;
        r.out_chip             = c.chip;
        r.out_channel          = c.channel;
        r.expected             = noise_level;
        r.triggers             = addr_ok ? trig_cnt[ent] : '0;
        r.retrigger_starts     = addr_ok ? start_cnt[ent] : '0;
        r.retrigger_trains     = addr_ok ? train_cnt[ent] : '0;
        r.out_of_range_charges = addr_ok ? range_cnt[ent] : '0;
        expected_readouts.insert(expected_readouts.size(), r);
      end
      default: ;
    endcase
  endfunction

  // Command driver: holds a command until the block takes it, then may idle.
  always @(posedge clk) begin
    logic launch;
    launch = 1'b0;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) apply_command(item);
      if (!start || !busy) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (pending_cmds.size() != 0) begin
          launch = 1'b1;
          item <= pending_cmds.pop_front();
          if (idle_on && $urandom_range(0, 4) == 0) gap_left = $urandom_range(1, 7);
        end
        start <= launch;
      end
    end
  end

  task automatic check_field(string nm, logic [23:0] want, logic [23:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("readout %s mismatch: expected %0h got %0h", nm, want, got);
    end
  endtask

  // Readout monitor: every strobed result is matched against the oldest prediction.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && result_valid) begin
      if (expected_readouts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected readout transaction %h", result);
      end else begin
        want = expected_readouts.pop_front();
        check_field("out_layer", 24'(want.out_layer), 24'(result.out_layer));
        check_field("out_chip", 24'(want.out_chip), 24'(result.out_chip));
        check_field("out_channel", 24'(want.out_channel), 24'(result.out_channel));
        check_field("expected", want.expected, result.expected);
        check_field("triggers", want.triggers, result.triggers);
        check_field("retrigger_starts", want.retrigger_starts, result.retrigger_starts);
        check_field("retrigger_trains", want.retrigger_trains, result.retrigger_trains);
        check_field("out_of_range_charges", want.out_of_range_charges,
                    result.out_of_range_charges);
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [23:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_LAYERS_IN_USE:  lim_layers  = val[3:0];
      REG_EXPECTED_NOISE: noise_level = val;
      REG_CHARGE_LOW:     win_lo      = val[11:0];
      REG_CHARGE_HIGH:    win_hi      = val[11:0];
      default: ;
    endcase
  endtask

  task automatic configure(logic [3:0] ly, logic [23:0] noise, logic [11:0] lo,
                           logic [11:0] hi);
    write_reg(REG_LAYERS_IN_USE, 24'(ly));
    write_reg(REG_EXPECTED_NOISE, noise);
    write_reg(REG_CHARGE_LOW, 24'(lo));
    write_reg(REG_CHARGE_HIGH, 24'(hi));
  endtask

  // Wait until every command is taken and every readout has come, then let the
  // last command finish inside the block.
  task automatic drain();
    @(negedge clk);
    while (pending_cmds.size() != 0 || start || expected_readouts.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic in_item_t rand_cmd(logic [1:0] op);
    logic [63:0] r;
    in_item_t    c;
    r = {$urandom(), $urandom()};
    c = r[$bits(in_item_t)-1:0];
    c.op = op;
    return c;
  endfunction

  function automatic in_item_t sample_cmd(logic [3:0] ly, logic [3:0] cp, logic [3:0] cl,
                                          logic [5:0] ch, logic [7:0] code, logic hit,
                                          logic [11:0] q);
    in_item_t c;
    c = rand_cmd(OP_SAMPLE);
    c.layer      = ly;
    c.chip       = cp;
    c.cell_req   = cl;
    c.channel    = ch;
    c.cell_valid = 1'b1;
    c.bad_bcid   = code;
    c.hit_high   = hit;
    c.charge     = q;
    return c;
  endfunction

  function automatic in_item_t read_cmd(logic [3:0] ly, logic [3:0] cp, logic [5:0] ch);
    in_item_t c;
    c = rand_cmd(OP_READ);
    c.layer   = ly;
    c.chip    = cp;
    c.channel = ch;
    return c;
  endfunction

  // Mostly clean codes and retriggers, with the quiet codes and negatives mixed in.
  function automatic logic [7:0] pick_code();
    case ($urandom_range(0, 9))
      0, 1, 2: return 8'd0;
      3:       return 8'($urandom_range(1, 2));
      8, 9:    return 8'($urandom_range(128, 255));
      default: return 8'($urandom_range(3, 127));
    endcase
  endfunction

  // Charges cluster around both window edges.
  function automatic logic [11:0] pick_charge();
    int v;
    case ($urandom_range(0, 3))
      0:       v = int'(win_lo) + int'($urandom_range(0, 2)) - 1;
      1:       v = int'(win_hi) + int'($urandom_range(0, 2)) - 1;
      default: v = int'($urandom_range(0, 4095));
    endcase
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[11:0];
  endfunction

  function automatic logic [3:0] pick_layer();
    case ($urandom_range(0, 4))
      0, 1:    return 4'($urandom_range(0, lim_layers));
      2:       return 4'($urandom_range(0, 2));
      3:       return lim_layers - 4'd1;
      default: return 4'($urandom_range(0, 15));
    endcase
  endfunction

  // Append one command to the pending queue.
  function automatic void add_cmd(in_item_t c);
    pending_cmds.insert(pending_cmds.size(), c);
  endfunction

  function automatic void note_addr(logic [3:0] ly, logic [3:0] cp, logic [5:0] ch);
    entry_addr_t a;
    a = '{layer: ly, chip: cp, channel: ch};
    hit_addrs.insert(hit_addrs.size(), a);
    if (hit_addrs.size() > 64) void'(hit_addrs.pop_front());
  endfunction

  function automatic void queue_read();
    entry_addr_t a;
    if (hit_addrs.size() != 0 && $urandom_range(0, 4) != 0) begin
      a = hit_addrs[$urandom_range(0, hit_addrs.size() - 1)];
      add_cmd(read_cmd(a.layer, a.chip, a.channel));
    end else begin
      add_cmd(rand_cmd(OP_READ));
    end
  endfunction

  // One event: ascending cells on a few chips, with some broken pieces.
  function automatic void queue_event();
    logic [3:0] ly;
    logic [3:0] cp;
    logic [5:0] ch;
    logic [7:0] code;
    in_item_t   c;
    int         cell_no;
    if ($urandom_range(0, 7) != 0) add_cmd(rand_cmd(OP_EVENT));
    repeat ($urandom_range(1, 3)) begin
      ly = pick_layer();
      cp = $urandom_range(0, 1) ? hot_chips[$urandom_range(0, 2)] : 4'($urandom_range(0, 15));
      cell_no = $urandom_range(0, 4);
      while (cell_no < DefCells) begin
        code = pick_code();
        repeat ($urandom_range(1, 3)) begin
          ch = $urandom_range(0, 1) ? hot_chans[$urandom_range(0, 3)]
                                    : 6'($urandom_range(0, 63));
          c = sample_cmd(ly, cp, 4'(cell_no), ch, code, $urandom_range(0, 3) != 0,
                         pick_charge());
          c.cell_valid = $urandom_range(0, 15) != 0;
          add_cmd(c);
          note_addr(ly, cp, ch);
        end
        cell_no += $urandom_range(1, 4);
      end
      // A sample out of cell order on the same chip.
      if ($urandom_range(0, 3) == 0) begin
        ch = hot_chans[$urandom_range(0, 3)];
        add_cmd(sample_cmd(ly, cp, 4'($urandom_range(0, 14)), ch,
                           8'($urandom_range(3, 127)), 1'b1, pick_charge()));
        note_addr(ly, cp, ch);
      end
    end
    if ($urandom_range(0, 4) == 0) add_cmd(rand_cmd(OP_SAMPLE));
    if ($urandom_range(0, 4) == 0) add_cmd(rand_cmd(OP_SPARE));
    repeat ($urandom_range(1, 4)) queue_read();
  endfunction

  task automatic run_phase(int n_items, bit idling);
    int made;
    made = 0;
    @(negedge clk);
    idle_on = idling;
    hot_chips[0] = 4'd0;
    hot_chips[1] = 4'd15;
    hot_chips[2] = 4'($urandom_range(0, 15));
    hot_chans[0] = 6'd0;
    hot_chans[1] = 6'd63;
    hot_chans[2] = 6'($urandom_range(0, 63));
    hot_chans[3] = 6'($urandom_range(0, 63));
    while (made < n_items) begin
      made -= pending_cmds.size();
      queue_event();
      made += pending_cmds.size();
    end
    drain();
  endtask

  // Directed commands: window edges, every code class and each ignore rule.
  task automatic directed_part();
    in_item_t c;
    @(negedge clk);
    idle_on = 1'b1;
    add_cmd(rand_cmd(OP_EVENT));
    add_cmd(sample_cmd(4'd0, 4'd0, 4'd2, 6'd0, 8'd3, 1'b1, 12'd50));
    add_cmd(sample_cmd(4'd0, 4'd0, 4'd2, 6'd1, 8'd3, 1'b1, 12'd1000));
    add_cmd(sample_cmd(4'd0, 4'd0, 4'd3, 6'd0, 8'd127, 1'b1, 12'd4095));
    add_cmd(sample_cmd(4'd0, 4'd0, 4'd1, 6'd0, 8'd4, 1'b1, 12'd0));
    // Retrigger without a hit still marks the chip.
    add_cmd(sample_cmd(4'd0, 4'd1, 4'd4, 6'd5, 8'd3, 1'b0, 12'd0));
    add_cmd(sample_cmd(4'd0, 4'd1, 4'd4, 6'd5, 8'd3, 1'b1, 12'd100));
    add_cmd(sample_cmd(4'd14, 4'd15, 4'd14, 6'd63, 8'd0, 1'b1, 12'd4095));
    add_cmd(sample_cmd(4'd14, 4'd15, 4'd14, 6'd63, 8'd0, 1'b0, 12'd0));
    add_cmd(sample_cmd(4'd14, 4'd15, 4'd14, 6'd63, 8'd1, 1'b1, 12'd0));
    add_cmd(sample_cmd(4'd14, 4'd15, 4'd14, 6'd63, 8'd2, 1'b1, 12'd0));
    add_cmd(sample_cmd(4'd14, 4'd15, 4'd14, 6'd63, 8'hFF, 1'b1, 12'd0));
    add_cmd(sample_cmd(4'd14, 4'd15, 4'd14, 6'd63, 8'h80, 1'b1, 12'd0));
    // Invalid cell, cell index out of range and layer out of range are ignored.
    c = sample_cmd(4'd0, 4'd0, 4'd2, 6'd0, 8'd3, 1'b1, 12'd0);
    c.cell_valid = 1'b0;
    add_cmd(c);
    add_cmd(sample_cmd(4'd0, 4'd0, 4'd15, 6'd0, 8'd0, 1'b1, 12'd0));
    add_cmd(sample_cmd(4'd15, 4'd0, 4'd0, 6'd0, 8'd0, 1'b1, 12'd0));
    add_cmd(rand_cmd(OP_SPARE));
    add_cmd(read_cmd(4'd0, 4'd0, 6'd0));
    add_cmd(read_cmd(4'd0, 4'd0, 6'd1));
    add_cmd(read_cmd(4'd0, 4'd1, 6'd5));
    add_cmd(read_cmd(4'd14, 4'd15, 6'd63));
    add_cmd(read_cmd(4'd15, 4'd15, 6'd63));
    // A new event forgets the marks, so a later cell starts a new train.
    add_cmd(rand_cmd(OP_EVENT));
    add_cmd(sample_cmd(4'd0, 4'd0, 4'd5, 6'd0, 8'd3, 1'b1, 12'd2000));
    add_cmd(read_cmd(4'd0, 4'd0, 6'd0));
    drain();
  endtask

  // Main sequence: reset, directed commands, then random phases under several settings.
  initial begin
    foreach (trig_cnt[i]) begin
      trig_cnt[i]  = '0;
      start_cnt[i] = '0;
      train_cnt[i] = '0;
      range_cnt[i] = '0;
    end
    foreach (retrig_seen[i]) retrig_seen[i] = 1'b0;
    lim_layers  = LAYERS_IN_USE_RST;
    noise_level = EXPECTED_NOISE_RST;
    win_lo      = CHARGE_LOW_RST;
    win_hi      = CHARGE_HIGH_RST;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    configure(4'd15, 24'hFFFFFF, 12'd100, 12'd1000);
    directed_part();

    // Single layer with the widest window.
    configure(4'd1, 24'd0, 12'd0, 12'd4095);
    run_phase(330, 1'b1);
    // All layers with an inverted window.
    configure(4'd15, 24'h5A5A5A, 12'd4095, 12'd0);
    run_phase(330, 1'b1);
    configure(4'($urandom_range(1, 15)), 24'($urandom()), 12'($urandom_range(0, 2000)),
              12'($urandom_range(1500, 4095)));
    run_phase(330, 1'b1);
    configure(4'($urandom_range(1, 15)), 24'($urandom()), 12'($urandom()), 12'($urandom()));
    run_phase(330, 1'b1);
    // Closing stretch at full rate.
    configure(4'd15, 24'hA5A5A5, 12'd100, 12'd1000);
    run_phase(250, 1'b0);

    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_readouts.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/cntc_pkg.sv
hw/rtl/cntc_count_ram.sv
hw/rtl/cntc_mark_store.sv
hw/rtl/channel_noise_trigger_counter_core.sv
test/tb.sv
